/* src/assert_macros.svh */
// Assertion macros used by the checker file of the hash table unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define CHT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define CHT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cht_pkg.sv */
// Types and constants of the coalesced hash table unit.
// No dependencies; used by the top level and its checker.
package cht_pkg;

    localparam int KEY_W      = 16;
    localparam int DATA_W     = 16;
    localparam int TS_W       = 5;
    localparam int STATUS_W   = 2;
    localparam int SLOT_IDX_W = 4;

    localparam logic [TS_W-1:0] TABLE_SIZE_RESET = 5'd10;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DELETED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_PMOD,
        S_PREAD,
        S_PCHECK,
        S_WRITE2,
        S_DONE
    } state_t;

endpackage

/* src/cht_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/coalesced_hash_table_unit.sv */
// Coalesced hash table: slot store in one RAM, walk and probe sequencer, shared divider.
// Depends on cht_pkg and cht_ram.
//
//  channel   direction  signals                                 handshake
//  s_        in         s_cmd, s_key, s_data_value              s_valid / s_ready
//  m_        out        m_status, m_slot_index                  m_valid / m_ready
//  cfg_      in         cfg_data (table_size)                   cfg_valid / cfg_ready
//
// One transaction at a time. A transaction is accepted, the bit-serial divider forms
// the hash remainder, and each chain slot visited takes a RAM read and a check. An
// insert that probes then forms the start remainder and reads and checks each probed
// slot; the link is written back when a link changes, and then the result is loaded.
// Slots are read one at a time, through the RAM's single read port.
// Reset empties all slots at once through per-slot written flags; no clearing pass.
// A new transaction is taken while the previous result still waits on m_.
module coalesced_hash_table_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [cht_pkg::KEY_W-1:0]      s_key,
    input  logic [cht_pkg::DATA_W-1:0]     s_data_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cht_pkg::STATUS_W-1:0]   m_status,
    output logic [cht_pkg::SLOT_IDX_W-1:0] m_slot_index,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cht_pkg::TS_W-1:0]       cfg_data
);

    import cht_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    typedef struct packed {
        logic              valid;
        logic              has_link;
        logic [IDX_W-1:0]  link;
        logic [DATA_W-1:0] data;
    } slot_word_t;

    localparam int WORD_W = $bits(slot_word_t);

    state_t state_reg, state_next;

    logic [TS_W-1:0]       table_size_reg;
    logic [TS_W-1:0]       ts_eff;
    logic [SLOT_COUNT-1:0] written_reg;

    logic                  cmd_reg, cmd_next;
    logic [DATA_W-1:0]     data_reg, data_next;
    logic [KEY_W-1:0]      div_dvd_reg, div_dvd_next;
    logic [TS_W-1:0]       div_rem_reg, div_rem_next;
    logic [3:0]            div_cnt_reg, div_cnt_next;
    logic [TS_W:0]         div_trial;
    logic [TS_W-1:0]       div_step;

    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;
    slot_word_t            prev_word_reg, prev_word_next;
    logic                  has_prev_reg, has_prev_next;
    logic [IDX_W:0]        steps_reg, steps_next;
    logic [IDX_W-1:0]      cand_reg, cand_next;
    logic [TS_W-1:0]       j_reg, j_next;
    logic [IDX_W-1:0]      aux_addr_reg, aux_addr_next;
    slot_word_t            aux_word_reg, aux_word_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_IDX_W-1:0] res_slot_reg, res_slot_next;

    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [SLOT_IDX_W-1:0] m_slot_index_reg, m_slot_index_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    slot_word_t            ram_wword;
    logic [IDX_W-1:0]      ram_raddr;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [WORD_W-1:0]     ram_rdata;
    slot_word_t            word;

    logic is_insert, div_last, step_limit, match, probe_last, ts_one, out_free;

    cht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wword),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slots never written since reset read as empty with no link
    assign word = written_reg[rd_addr_reg] ? slot_word_t'(ram_rdata) : '0;

    always_comb begin
        if (table_size_reg == '0) begin
            ts_eff = TS_W'(1);
        end else if (32'(table_size_reg) > SLOT_COUNT) begin
            ts_eff = TS_W'(SLOT_COUNT);
        end else begin
            ts_eff = table_size_reg;
        end
    end

    // one restoring-division step per cycle
    assign div_trial = {div_rem_reg, div_dvd_reg[KEY_W-1]};
    assign div_step  = (div_trial >= {1'b0, ts_eff}) ? TS_W'(div_trial - {1'b0, ts_eff})
                                                     : TS_W'(div_trial);

    assign is_insert  = (cmd_reg == CMD_INSERT);
    assign div_last   = (div_cnt_reg == 4'hF);
    assign step_limit = (32'(steps_reg) >= SLOT_COUNT);
    assign match      = word.valid && (word.data == data_reg);
    assign probe_last = (j_reg == TS_W'(ts_eff - TS_W'(1)));
    assign ts_one     = (ts_eff == TS_W'(1));
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_slot_index_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_HASH;
            S_HASH:  if (div_last) state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK: begin
                if (is_insert) begin
                    priority if (!word.valid) state_next = S_DONE;
                    else if (!word.has_link) state_next = S_PMOD;
                    else if (step_limit)     state_next = S_DONE;
                    else                     state_next = S_READ;
                end else begin
                    priority if (match) state_next = has_prev_reg ? S_WRITE2 : S_DONE;
                    else if (!word.has_link || step_limit) state_next = S_DONE;
                    else state_next = S_READ;
                end
            end
            S_PMOD: begin
                if (div_last) state_next = ts_one ? S_DONE : S_PREAD;
            end
            S_PREAD: state_next = S_PCHECK;
            S_PCHECK: begin
                priority if (!word.valid) state_next = S_WRITE2;
                else if (probe_last)      state_next = S_DONE;
                else                      state_next = S_PREAD;
            end
            S_WRITE2: state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and RAM port
    always_comb begin
        cmd_next          = cmd_reg;
        data_next         = data_reg;
        div_dvd_next      = div_dvd_reg;
        div_rem_next      = div_rem_reg;
        div_cnt_next      = div_cnt_reg;
        cur_next          = cur_reg;
        prev_next         = prev_reg;
        prev_word_next    = prev_word_reg;
        has_prev_next     = has_prev_reg;
        steps_next        = steps_reg;
        cand_next         = cand_reg;
        j_next            = j_reg;
        aux_addr_next     = aux_addr_reg;
        aux_word_next     = aux_word_reg;
        res_status_next   = res_status_reg;
        res_slot_next     = res_slot_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_slot_index_next = m_slot_index_reg;
        ram_we            = 1'b0;
        ram_waddr         = cur_reg;
        ram_wword         = word;
        ram_raddr         = cur_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next     = s_cmd;
                    data_next    = s_data_value;
                    div_dvd_next = s_key;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                end
            end
            S_HASH, S_PMOD: begin
                div_dvd_next = {div_dvd_reg[KEY_W-2:0], 1'b0};
                div_rem_next = div_step;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_last) begin
                    if (state_reg == S_HASH) begin
                        cur_next      = IDX_W'(div_step);
                        steps_next    = '0;
                        has_prev_next = 1'b0;
                    end else begin
                        cand_next = IDX_W'(div_step);
                        j_next    = TS_W'(1);
                        if (ts_one) begin
                            res_status_next = STATUS_FULL;
                            res_slot_next   = '0;
                        end
                    end
                end
            end
            S_READ: begin
                ram_raddr = cur_reg;
            end
            S_CHECK: begin
                if (is_insert) begin
                    priority if (!word.valid) begin
                        // emptied slot on the chain: fill in place, links kept
                        ram_we          = 1'b1;
                        ram_waddr       = cur_reg;
                        ram_wword       = word;
                        ram_wword.valid = 1'b1;
                        ram_wword.data  = data_reg;
                        res_status_next = STATUS_INSERTED;
                        res_slot_next   = SLOT_IDX_W'(cur_reg);
                    end else if (!word.has_link) begin
                        // chain tail: probe from tail+1 mod size
                        aux_addr_next = cur_reg;
                        aux_word_next = word;
                        div_dvd_next  = KEY_W'(cur_reg) + KEY_W'(1);
                        div_rem_next  = '0;
                        div_cnt_next  = '0;
                    end else if (step_limit) begin
                        res_status_next = STATUS_FULL;
                        res_slot_next   = '0;
                    end else begin
                        steps_next = steps_reg + 1'b1;
                        cur_next   = word.link;
                    end
                end else begin
                    priority if (match) begin
                        ram_we          = 1'b1;
                        ram_waddr       = cur_reg;
                        ram_wword       = word;
                        ram_wword.valid = 1'b0;
                        if (has_prev_reg) begin
                            ram_wword.has_link     = 1'b0;
                            ram_wword.link         = '0;
                            aux_addr_next          = prev_reg;
                            aux_word_next          = prev_word_reg;
                            aux_word_next.has_link = word.has_link;
                            aux_word_next.link     = word.link;
                        end
                        res_status_next = STATUS_DELETED;
                        res_slot_next   = SLOT_IDX_W'(cur_reg);
                    end else if (!word.has_link || step_limit) begin
                        res_status_next = STATUS_NOT_FOUND;
                        res_slot_next   = '0;
                    end else begin
                        steps_next     = steps_reg + 1'b1;
                        prev_next      = cur_reg;
                        prev_word_next = word;
                        has_prev_next  = 1'b1;
                        cur_next       = word.link;
                    end
                end
            end
            S_PREAD: begin
                ram_raddr = cand_reg;
            end
            S_PCHECK: begin
                priority if (!word.valid) begin
                    ram_we                 = 1'b1;
                    ram_waddr              = cand_reg;
                    ram_wword              = word;
                    ram_wword.valid        = 1'b1;
                    ram_wword.data         = data_reg;
                    aux_word_next.has_link = 1'b1;
                    aux_word_next.link     = cand_reg;
                    res_status_next        = STATUS_INSERTED;
                    res_slot_next          = SLOT_IDX_W'(cand_reg);
                end else if (probe_last) begin
                    res_status_next = STATUS_FULL;
                    res_slot_next   = '0;
                end else begin
                    j_next    = j_reg + TS_W'(1);
                    cand_next = (32'(cand_reg) + 1 == 32'(ts_eff)) ? '0
                                                                   : cand_reg + IDX_W'(1);
                end
            end
            S_WRITE2: begin
                ram_we    = 1'b1;
                ram_waddr = aux_addr_reg;
                ram_wword = aux_word_reg;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_slot_index_next = res_slot_reg;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            written_reg    <= '0;
            table_size_reg <= TABLE_SIZE_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (ram_we) begin
                written_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                table_size_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cmd_reg          <= cmd_next;
        data_reg         <= data_next;
        div_dvd_reg      <= div_dvd_next;
        div_rem_reg      <= div_rem_next;
        div_cnt_reg      <= div_cnt_next;
        cur_reg          <= cur_next;
        prev_reg         <= prev_next;
        prev_word_reg    <= prev_word_next;
        has_prev_reg     <= has_prev_next;
        steps_reg        <= steps_next;
        cand_reg         <= cand_next;
        j_reg            <= j_next;
        aux_addr_reg     <= aux_addr_next;
        aux_word_reg     <= aux_word_next;
        res_status_reg   <= res_status_next;
        res_slot_reg     <= res_slot_next;
        m_status_reg     <= m_status_next;
        m_slot_index_reg <= m_slot_index_next;
        rd_addr_reg      <= ram_raddr;
    end

endmodule

/* src/cht_checker.sv */
// Port-level checker for coalesced_hash_table_unit, attached by bind.
// Depends on cht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cht_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [cht_pkg::STATUS_W-1:0]   m_status,
    input logic [cht_pkg::SLOT_IDX_W-1:0] m_slot_index
);

    import cht_pkg::*;

    // transactions accepted on s_ whose result has not left m_
    logic [1:0] pend_reg, pend_next;

    always_comb begin
        pend_next = pend_reg + 2'((s_valid && s_ready) ? 1 : 0)
                             - 2'((m_valid && m_ready) ? 1 : 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `CHT_ASSERT_IMPL(a_no_slot_on_miss, aclk, aresetn,
        m_valid && (m_status == STATUS_FULL || m_status == STATUS_NOT_FOUND),
        m_slot_index == '0, "slot index nonzero on full or not found")

    `CHT_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_slot_index), "stalled result changed")

    `CHT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input taken while a transaction is in flight")

    `CHT_ASSERT_IMPL(a_result_has_source, aclk, aresetn, m_valid, pend_reg != 2'd0,
        "result without an accepted transaction")

    `CHT_ASSERT_IMPL(a_pending_bounded, aclk, aresetn, 1'b1, pend_reg != 2'd3,
        "more than two transactions outstanding")

endmodule

bind coalesced_hash_table_unit cht_checker u_cht_checker (.*);

/* dv/tb_coalesced_hash_table_unit.sv */
// Self-checking testbench for coalesced_hash_table_unit: a mirror of the slot store
// predicts status and slot of every request; results are compared in order.
// Depends on cht_pkg and the RTL of the unit.
module tb_coalesced_hash_table_unit;
    import cht_pkg::*;

    localparam int SLOTS          = 16;
    localparam logic [4:0] LINK_NONE = 5'h1f;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 183;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RECENT_DEPTH   = 24;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot;
    } outcome_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } stored_pair_t;

    // Mirror of the slot store plus the queue of outcomes still owed by the unit.
    class hash_table_tracker;
        logic [TS_W-1:0]   table_size;
        logic [DATA_W-1:0] slot_data [SLOTS];
        bit                slot_valid [SLOTS];
        logic [4:0]        next_link [SLOTS];
        outcome_t          pending_outcomes [$];
        int                errors;
        int                results_seen;

        function new();
            table_size   = TABLE_SIZE_RESET;
            errors       = 0;
            results_seen = 0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_data[i]  = '0;
                slot_valid[i] = 1'b0;
                next_link[i]  = LINK_NONE;
            end
        endfunction

        function int unsigned size_in_use();
            if (table_size == 0)
                return 1;
            if (table_size > SLOTS)
                return SLOTS;
            return table_size;
        endfunction

        function outcome_t insert_entry(logic [KEY_W-1:0] key, logic [DATA_W-1:0] d);
            int unsigned ts;
            int unsigned cur;
            int unsigned steps;
            int unsigned cand;
            ts    = size_in_use();
            cur   = key % ts;
            steps = 0;
            forever begin
                if (!slot_valid[cur]) begin
                    slot_data[cur]  = d;
                    slot_valid[cur] = 1'b1;
                    return '{status: STATUS_INSERTED, slot: SLOT_IDX_W'(cur)};
                end
                if (next_link[cur] >= SLOTS)
                    break;
                if (steps >= SLOTS)
                    return '{status: STATUS_FULL, slot: '0};
                steps++;
                cur = next_link[cur];
            end
            // cur is the valid tail of the chain; probe only below the size in use
            for (int unsigned j = 1; j < ts; j++) begin
                cand = (cur + j) % ts;
                if (!slot_valid[cand]) begin
                    slot_data[cand]  = d;
                    slot_valid[cand] = 1'b1;
                    next_link[cur]   = 5'(cand);
                    return '{status: STATUS_INSERTED, slot: SLOT_IDX_W'(cand)};
                end
            end
            return '{status: STATUS_FULL, slot: '0};
        endfunction

        function outcome_t delete_entry(logic [KEY_W-1:0] key, logic [DATA_W-1:0] d);
            int unsigned ts;
            int unsigned cur;
            int unsigned steps;
            int          prev;
            ts    = size_in_use();
            cur   = key % ts;
            steps = 0;
            prev  = -1;
            forever begin
                if (slot_valid[cur] && slot_data[cur] == d)
                    break;
                if (next_link[cur] >= SLOTS || steps >= SLOTS)
                    return '{status: STATUS_NOT_FOUND, slot: '0};
                steps++;
                prev = cur;
                cur  = next_link[cur];
            end
            slot_valid[cur] = 1'b0;
            // the head keeps its link; a slot further along is unlinked
            if (prev >= 0) begin
                next_link[prev] = next_link[cur];
                next_link[cur]  = LINK_NONE;
            end
            return '{status: STATUS_DELETED, slot: SLOT_IDX_W'(cur)};
        endfunction

        function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] d);
            if (cmd == CMD_INSERT)
                pending_outcomes.push_back(insert_entry(key, d));
            else
                pending_outcomes.push_back(delete_entry(key, d));
        endfunction

        task report(string msg);
            $display("ERROR result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task check_outcome(logic [STATUS_W-1:0] status, logic [SLOT_IDX_W-1:0] slot);
            outcome_t want;
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                report($sformatf("unexpected result status %0d slot %0d", status, slot));
                return;
            end
            want = pending_outcomes.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
            if (slot !== want.slot)
                report($sformatf("slot_index %0d, expected %0d", slot, want.slot));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cmd;
    logic [KEY_W-1:0]      s_key;
    logic [DATA_W-1:0]     s_data_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_IDX_W-1:0] m_slot_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TS_W-1:0]       cfg_data;

    hash_table_tracker tracker;
    stored_pair_t      recent_pairs [$];
    int                tx_idle_pct;
    int                rx_stall_pct;
    int                rx_hold_requests;
    int                cycle_count;

    coalesced_hash_table_unit #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_key       (s_key),
        .s_data_value(s_data_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_slot_index(m_slot_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_outcome(m_status, m_slot_index);
    end

    // Result side: random stalls, plus a long hold-off each time one is requested.
    initial begin
        int hold_served;
        hold_served = 0;
        m_ready     = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_requests != hold_served) begin
                hold_served = rx_hold_requests;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(logic cmd, logic [KEY_W-1:0] key, logic [DATA_W-1:0] d);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_key        <= key;
        s_data_value <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(cmd, key, d);
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.pending_outcomes.size() != 0);
    endtask

    task automatic write_table_size(logic [TS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.table_size = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly inserts and deletes of pairs stored earlier, so chains grow, break and
    // refill; a tenth are deletes of random pairs that rarely match.
    task automatic send_random_request();
        stored_pair_t pair;
        int unsigned  r;
        int unsigned  pick;
        r = $urandom_range(99);
        if (r < 50 || recent_pairs.size() == 0) begin
            pair.key  = ($urandom_range(9) < 7) ? KEY_W'($urandom_range(63)) : KEY_W'($urandom);
            pair.data = ($urandom_range(1) == 0) ? DATA_W'($urandom_range(15))
                                                 : DATA_W'($urandom);
            recent_pairs.push_back(pair);
            if (recent_pairs.size() > RECENT_DEPTH)
                void'(recent_pairs.pop_front());
            send_request(CMD_INSERT, pair.key, pair.data);
        end else if (r < 90) begin
            pick = $urandom_range(recent_pairs.size() - 1);
            pair = recent_pairs[pick];
            recent_pairs.delete(pick);
            send_request(CMD_DELETE, pair.key, pair.data);
        end else begin
            send_request(CMD_DELETE, KEY_W'($urandom), DATA_W'($urandom));
        end
    endtask

    initial begin
        logic [TS_W-1:0] phase_sizes [PHASES];
        tracker          = new();
        phase_sizes      = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd3, 5'd12, 5'd20};
        phase_sizes[PHASES-1] = TS_W'($urandom_range(31));
        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        rx_hold_requests = 0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_cmd            = CMD_INSERT;
        s_key            = '0;
        s_data_value     = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset size of ten: chain building, middle unlink, head clear and refill
        send_request(CMD_INSERT, 16'd0, 16'h0000);
        send_request(CMD_INSERT, 16'd10, 16'hffff);
        send_request(CMD_INSERT, 16'd20, 16'h1234);
        send_request(CMD_INSERT, 16'hffff, 16'haaaa);
        send_request(CMD_DELETE, 16'd0, 16'hffff);
        send_request(CMD_DELETE, 16'd0, 16'h0000);
        send_request(CMD_INSERT, 16'd30, 16'h5555);
        send_request(CMD_DELETE, 16'd3, 16'h0007);
        send_request(CMD_DELETE, 16'd10, 16'h9999);
        wait_for_drain();

        // lowered size: links past the size are followed, probing stays below it
        write_table_size(5'd2);
        send_request(CMD_INSERT, 16'd1, 16'h0001);
        send_request(CMD_INSERT, 16'd0, 16'h0002);
        send_request(CMD_DELETE, 16'd4, 16'h1234);
        send_request(CMD_INSERT, 16'd7, 16'h8000);
        wait_for_drain();

        // zero acts as one
        write_table_size(5'd0);
        send_request(CMD_INSERT, 16'hffff, 16'h0003);
        send_request(CMD_DELETE, 16'd5, 16'h5555);
        send_request(CMD_INSERT, 16'd9, 16'h4321);
        wait_for_drain();

        // above the slot count acts as the slot count
        write_table_size(5'd31);
        send_request(CMD_INSERT, 16'd16, 16'h0010);
        send_request(CMD_INSERT, 16'd15, 16'hffff);
        send_request(CMD_INSERT, 16'd31, 16'h0f0f);
        send_request(CMD_DELETE, 16'd47, 16'h0f0f);
        send_request(CMD_DELETE, 16'd0, 16'hffff);
        wait_for_drain();

        for (int p = 0; p < PHASES; p++) begin
            write_table_size(phase_sizes[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            // fill the unit while the result side is held off
            if (p == 0)
                rx_hold_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == PHASE_ITEMS / 2)
                    wait_for_drain();
                send_random_request();
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (tracker.errors == 0 && tracker.pending_outcomes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
